// ===== sv/vector_pair_dot_norm_relation_top_assert.svh =====
// Assertion macros for the vector pair dot product and norm block.
`ifndef VECTOR_PAIR_DOT_NORM_RELATION_TOP_ASSERT_SVH
`define VECTOR_PAIR_DOT_NORM_RELATION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define VPDN_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define VPDN_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define VPDN_ASSERT_SAME(lbl, ck, rn, ante, cons, msg)
`define VPDN_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

// ===== sv/vpdn_pkg.sv =====
// Shared widths and defaults for the vector pair dot product and norm block.
package vpdn_pkg;

	// Transfer field widths
	localparam int IN_BITS   = 16;
	localparam int DOT_BITS  = 40;
	localparam int MAG_BITS  = 20;

	// Element precision taken from each input field (low bits, two's complement)
	localparam int ELEM_BITS = 16;

	// Default maximum vector length
	localparam int MAX_LENGTH_DEF = 256;

endpackage

// ===== sv/vpdn_if.sv =====
// Handshake channel interfaces for element pairs and results.
interface vpdn_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [vpdn_pkg::IN_BITS-1:0]  elem_a;
	logic signed [vpdn_pkg::IN_BITS-1:0]  elem_b;
	logic                                 last;

	modport source (output valid, output elem_a, output elem_b, output last, input ready);
	modport sink   (input valid, input elem_a, input elem_b, input last, output ready);
endinterface

interface vpdn_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [vpdn_pkg::DOT_BITS-1:0] dot;
	logic        [vpdn_pkg::MAG_BITS-1:0] mag_a;
	logic        [vpdn_pkg::MAG_BITS-1:0] mag_b;
	logic                                 orthogonal;
	logic                                 same_direction;
	logic                                 length_error;

	modport source (output valid, output dot, output mag_a, output mag_b, output orthogonal,
		output same_direction, output length_error, input ready);
	modport sink   (input valid, input dot, input mag_a, input mag_b, input orthogonal,
		input same_direction, input length_error, output ready);
endinterface

// ===== sv/vector_pair_dot_norm_relation_top.sv =====
// Dot product, Euclidean norms and direction flags over streamed element pairs.
// Each element pair steps through accept, three multiplies and a final add; no new pair
// is accepted until these are done. A last pair then runs two square roots and, when
// the length is valid, both norms are nonzero and the dot is positive, two shift-add
// products, then waits in an emit step until the result register is free.
// One wide adder is shared by accumulation, root steps and product steps.
// Reset (arst_n low, asynchronous) clears sums, element count, sequencer and valid.
`include "vector_pair_dot_norm_relation_top_assert.svh"

module vector_pair_dot_norm_relation_top #(
	parameter int MAX_LENGTH = vpdn_pkg::MAX_LENGTH_DEF
) (
	input logic            clk,
	input logic            arst_n,
	vpdn_in_if.sink        elems,
	vpdn_out_if.source     result
);

	localparam int EB     = vpdn_pkg::ELEM_BITS;
	localparam int DOTB   = vpdn_pkg::DOT_BITS;
	localparam int MAGB   = vpdn_pkg::MAG_BITS;
	localparam int LW     = $clog2(MAX_LENGTH);
	localparam int DOT_W  = 2 * EB + LW;
	localparam int SQ_W   = DOT_W - 1;
	localparam int PW     = 2 * SQ_W;
	localparam int NSTEP  = (SQ_W + 1) / 2;
	localparam int TOPPOS = 2 * ((SQ_W - 1) / 2);
	localparam int CNT_W  = $clog2(MAX_LENGTH + 2);
	localparam int STP_W  = $clog2(SQ_W);

	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_LENGTH);
	localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(MAX_LENGTH + 1);
	localparam logic [CNT_W-1:0] CNT_MIN  = CNT_W'(2);
	localparam logic [SQ_W-1:0]  BIT_TOP  = SQ_W'(1) << TOPPOS;
	localparam logic [STP_W-1:0] STP_ROOT = STP_W'(NSTEP - 1);
	localparam logic [STP_W-1:0] STP_PROD = STP_W'(SQ_W - 1);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_MUL_AB = 10'b00_0000_0010,
		ST_MUL_AA = 10'b00_0000_0100,
		ST_MUL_BB = 10'b00_0000_1000,
		ST_ADD_B  = 10'b00_0001_0000,
		ST_SQRT_A = 10'b00_0010_0000,
		ST_SQRT_B = 10'b00_0100_0000,
		ST_PROD_D = 10'b00_1000_0000,
		ST_PROD_S = 10'b01_0000_0000,
		ST_EMIT   = 10'b10_0000_0000
	} state_t;

	state_t                    state_q;
	logic signed [EB-1:0]      a_q;
	logic signed [EB-1:0]      b_q;
	logic                      last_q;
	logic                      take_q;
	logic [CNT_W-1:0]          count_q;
	logic signed [DOT_W-1:0]   dot_q;
	logic [SQ_W-1:0]           sqa_q;
	logic [SQ_W-1:0]           sqb_q;
	logic signed [2*EB-1:0]    prod_q;
	logic [SQ_W-1:0]           x_q;
	logic [SQ_W-1:0]           r_q;
	logic [SQ_W-1:0]           bit_q;
	logic [STP_W-1:0]          step_q;
	logic [MAGB-1:0]           mag_a_q;
	logic [PW-1:0]             mcand_q;
	logic [SQ_W-1:0]           mplier_q;
	logic [PW-1:0]             pacc_q;

	logic                      out_valid_q;
	logic signed [DOTB-1:0]    out_dot_q;
	logic [MAGB-1:0]           out_mag_a_q;
	logic [MAGB-1:0]           out_mag_b_q;
	logic                      out_orth_q;
	logic                      out_same_q;
	logic                      out_err_q;

	logic                      in_xfer;
	logic                      emit_go;
	logic signed [EB-1:0]      mul_x;
	logic signed [EB-1:0]      mul_y;
	logic [PW-1:0]             alu_a;
	logic [PW-1:0]             alu_b;
	logic                      alu_sub;
	logic [PW:0]               alu_sum;
	logic [SQ_W:0]             root_trial;
	logic                      root_ge;
	logic [SQ_W-1:0]           r_nxt;
	logic [SQ_W-1:0]           x_nxt;
	logic                      len_err;
	logic                      nonzero;
	logic                      same_cand;

	assign in_xfer     = elems.valid && elems.ready;
	assign elems.ready = (state_q == ST_IDLE);
	assign emit_go     = (state_q == ST_EMIT) && (!out_valid_q || result.ready);

	// Multiplier operand select: a*b, then a*a, then b*b
	always_comb begin
		case (state_q)
			ST_MUL_AB: begin
				mul_x = a_q;
				mul_y = b_q;
			end
			ST_MUL_AA: begin
				mul_x = a_q;
				mul_y = a_q;
			end
			default: begin
				mul_x = b_q;
				mul_y = b_q;
			end
		endcase
	end

	// Root step trial value
	assign root_trial = {1'b0, r_q} + {1'b0, bit_q};

	// Shared wide adder / subtractor
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			ST_MUL_AA: begin
				alu_a = PW'(dot_q);
				alu_b = PW'(prod_q);
			end
			ST_MUL_BB: begin
				alu_a = PW'(sqa_q);
				alu_b = PW'(prod_q);
			end
			ST_ADD_B: begin
				alu_a = PW'(sqb_q);
				alu_b = PW'(prod_q);
			end
			ST_SQRT_A, ST_SQRT_B: begin
				alu_a   = PW'(x_q);
				alu_b   = PW'(root_trial);
				alu_sub = 1'b1;
			end
			ST_PROD_D: begin
				alu_a = pacc_q;
				alu_b = mplier_q[0] ? mcand_q : '0;
			end
			ST_PROD_S: begin
				alu_a   = pacc_q;
				alu_b   = mplier_q[0] ? mcand_q : '0;
				alu_sub = 1'b1;
			end
			default: begin
				alu_a = '0;
			end
		endcase
		alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (PW + 1)'(alu_sub);
	end

	// Root step outcome: carry out means remainder >= trial
	assign root_ge = alu_sum[PW];
	assign r_nxt   = root_ge ? ((r_q >> 1) + bit_q) : (r_q >> 1);
	assign x_nxt   = root_ge ? alu_sum[SQ_W-1:0] : x_q;

	// Result flags
	assign len_err   = (count_q < CNT_MIN) || (count_q > CNT_MAX);
	assign nonzero   = (sqa_q != '0) && (sqb_q != '0);
	assign same_cand = !len_err && nonzero && !dot_q[DOT_W-1] && (dot_q != '0);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) state_q <= ST_MUL_AB;
				end
				ST_MUL_AB: state_q <= ST_MUL_AA;
				ST_MUL_AA: state_q <= ST_MUL_BB;
				ST_MUL_BB: state_q <= ST_ADD_B;
				ST_ADD_B: begin
					step_q  <= STP_ROOT;
					state_q <= last_q ? ST_SQRT_A : ST_IDLE;
				end
				ST_SQRT_A: begin
					if (step_q == '0) begin
						step_q  <= STP_ROOT;
						state_q <= ST_SQRT_B;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_SQRT_B: begin
					if (step_q == '0) begin
						step_q  <= STP_PROD;
						state_q <= same_cand ? ST_PROD_D : ST_EMIT;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_PROD_D: begin
					if (step_q == '0) begin
						step_q  <= STP_PROD;
						state_q <= ST_PROD_S;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_PROD_S: begin
					if (step_q == '0) state_q <= ST_EMIT;
					else step_q <= step_q - 1'b1;
				end
				ST_EMIT: begin
					if (emit_go) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Sums and element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dot_q   <= '0;
			sqa_q   <= '0;
			sqb_q   <= '0;
		end else begin
			if (in_xfer && (count_q < CNT_SAT)) count_q <= count_q + 1'b1;
			if (take_q && (state_q == ST_MUL_AA)) dot_q <= DOT_W'(alu_sum);
			if (take_q && (state_q == ST_MUL_BB)) sqa_q <= alu_sum[SQ_W-1:0];
			if (take_q && (state_q == ST_ADD_B))  sqb_q <= alu_sum[SQ_W-1:0];
			if (emit_go) begin
				count_q <= '0;
				dot_q   <= '0;
				sqa_q   <= '0;
				sqb_q   <= '0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			a_q    <= elems.elem_a[EB-1:0];
			b_q    <= elems.elem_b[EB-1:0];
			last_q <= elems.last;
			take_q <= (count_q < CNT_MAX);
		end
		prod_q <= mul_x * mul_y;
		case (state_q)
			ST_ADD_B: begin
				x_q   <= sqa_q;
				r_q   <= '0;
				bit_q <= BIT_TOP;
			end
			ST_SQRT_A: begin
				if (step_q == '0) begin
					mag_a_q <= MAGB'(r_nxt);
					x_q     <= sqb_q;
					r_q     <= '0;
					bit_q   <= BIT_TOP;
				end else begin
					x_q   <= x_nxt;
					r_q   <= r_nxt;
					bit_q <= bit_q >> 2;
				end
			end
			ST_SQRT_B: begin
				r_q      <= r_nxt;
				x_q      <= x_nxt;
				bit_q    <= bit_q >> 2;
				mcand_q  <= PW'(dot_q[SQ_W-1:0]);
				mplier_q <= dot_q[SQ_W-1:0];
				pacc_q   <= '0;
			end
			ST_PROD_D: begin
				pacc_q <= alu_sum[PW-1:0];
				if (step_q == '0) begin
					mcand_q  <= PW'(sqa_q);
					mplier_q <= sqb_q;
				end else begin
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end
			end
			ST_PROD_S: begin
				pacc_q   <= alu_sum[PW-1:0];
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
			default: begin
				pacc_q <= pacc_q;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_dot_q   <= DOTB'(dot_q);
			out_mag_a_q <= mag_a_q;
			out_mag_b_q <= MAGB'(r_q);
			out_orth_q  <= !len_err && nonzero && (dot_q == '0);
			out_same_q  <= same_cand && (pacc_q == '0);
			out_err_q   <= len_err;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.dot            = out_dot_q;
	assign result.mag_a          = out_mag_a_q;
	assign result.mag_b          = out_mag_b_q;
	assign result.orthogonal     = out_orth_q;
	assign result.same_direction = out_same_q;
	assign result.length_error   = out_err_q;

	// Checks
	`VPDN_ASSERT_NEXT(a_emit_loads, clk, arst_n, emit_go, out_valid_q, "emit did not load result")
	`VPDN_ASSERT_SAME(a_valid_src, clk, arst_n, $rose(out_valid_q), $past(state_q == ST_EMIT), "result valid without emit")
	`VPDN_ASSERT_SAME(a_same_excl, clk, arst_n, result.valid && result.same_direction, !result.orthogonal && !result.length_error && (result.dot != '0), "same direction with conflicting flags")
	`VPDN_ASSERT_SAME(a_count_sat, clk, arst_n, 1'b1, count_q <= CNT_SAT, "element count beyond saturation")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the vector pair dot product and norm block.
module tb;

	localparam int IN_BITS      = vpdn_pkg::IN_BITS;
	localparam int DOT_BITS     = vpdn_pkg::DOT_BITS;
	localparam int MAG_BITS     = vpdn_pkg::MAG_BITS;
	localparam int ELEM_BITS    = vpdn_pkg::ELEM_BITS;
	localparam int MAX_LEN      = vpdn_pkg::MAX_LENGTH_DEF;
	localparam int N_DIR        = 19;
	localparam int RANDOM_PAIRS = 900;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 200;

	typedef longint unsigned u64_t;

	// One vector summary as it leaves the block
	typedef struct packed {
		logic signed [DOT_BITS-1:0] dot;
		logic        [MAG_BITS-1:0] mag_a;
		logic        [MAG_BITS-1:0] mag_b;
		logic                       orthogonal;
		logic                       same_direction;
		logic                       length_error;
	} vec_summary_t;

	// Directed row: element pair, plus a hand-worked summary where fixed is set
	typedef struct packed {
		logic signed [IN_BITS-1:0] a;
		logic signed [IN_BITS-1:0] b;
		logic                      last;
		logic                      fixed;
		vec_summary_t              summary;
	} pair_row_t;

	typedef enum int {
		SHAPE_WIDE, SHAPE_NARROW, SHAPE_PARALLEL, SHAPE_ORTHO, SHAPE_ZERO, SHAPE_CORNER
	} vec_shape_t;

	localparam pair_row_t DIR_TAB [N_DIR] = '{
		// single element: length error, sums still reported
		'{16'sd3, 16'sd4, 1'b1, 1'b1, '{40'sd12, 20'd3, 20'd4, 1'b0, 1'b0, 1'b1}},
		// most negative elements, same direction
		'{-16'sd32768, -16'sd32768, 1'b0, 1'b0, '0},
		'{-16'sd32768, -16'sd32768, 1'b1, 1'b1,
			'{40'sd2147483648, 20'd46340, 20'd46340, 1'b0, 1'b1, 1'b0}},
		// most positive elements, same direction
		'{16'sd32767, 16'sd32767, 1'b0, 1'b0, '0},
		'{16'sd32767, 16'sd32767, 1'b1, 1'b1,
			'{40'sd2147352578, 20'd46339, 20'd46339, 1'b0, 1'b1, 1'b0}},
		// mixed extremes, large negative dot
		'{16'sd32767, -16'sd32768, 1'b0, 1'b0, '0},
		'{-16'sd32768, 16'sd32767, 1'b1, 1'b1,
			'{-40'sd2147418112, 20'd46340, 20'd46340, 1'b0, 1'b0, 1'b0}},
		// orthogonal unit vectors
		'{16'sd1, 16'sd0, 1'b0, 1'b0, '0},
		'{16'sd0, 16'sd1, 1'b1, 1'b1, '{40'sd0, 20'd1, 20'd1, 1'b1, 1'b0, 1'b0}},
		// zero first vector: no orthogonal flag
		'{16'sd0, 16'sd5, 1'b0, 1'b0, '0},
		'{16'sd0, 16'sd7, 1'b1, 1'b1, '{40'sd0, 20'd0, 20'd8, 1'b0, 1'b0, 1'b0}},
		// parallel, same way
		'{16'sd3, 16'sd6, 1'b0, 1'b0, '0},
		'{16'sd4, 16'sd8, 1'b1, 1'b1, '{40'sd50, 20'd5, 20'd10, 1'b0, 1'b1, 1'b0}},
		// parallel, opposite way
		'{16'sd2, -16'sd2, 1'b0, 1'b0, '0},
		'{-16'sd1, 16'sd1, 1'b1, 1'b1, '{-40'sd5, 20'd2, 20'd2, 1'b0, 1'b0, 1'b0}},
		// both vectors zero
		'{16'sd0, 16'sd0, 1'b0, 1'b0, '0},
		'{16'sd0, 16'sd0, 1'b1, 1'b1, '0},
		// alternating bit patterns
		'{16'sd21845, -16'sd21846, 1'b0, 1'b0, '0},
		'{-16'sd21846, 16'sd21845, 1'b1, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	vpdn_in_if  elems_ch();
	vpdn_out_if result_ch();

	vector_pair_dot_norm_relation_top #(
		.MAX_LENGTH(MAX_LEN)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.elems (elems_ch),
		.result(result_ch)
	);

	// Running sums of the vectors in flight
	longint          dot_sum;
	longint unsigned sq_a;
	longint unsigned sq_b;
	int              pair_cnt;

	vec_summary_t pending_summaries[$];
	int           mismatch_cnt;
	int           quiet_cycles;
	bit           idle_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Floor square root, one result bit per step
	function automatic logic [MAG_BITS-1:0] floor_root(input longint unsigned x);
		longint unsigned r;
		longint unsigned cand;
		r = 0;
		for (int i = MAG_BITS - 1; i >= 0; i--) begin
			cand = r | (u64_t'(1) << i);
			if (cand * cand <= x)
				r = cand;
		end
		return r[MAG_BITS-1:0];
	endfunction

	// Fold one element pair into the sums; on the last pair fill in the summary
	function automatic bit fold_pair(input logic signed [IN_BITS-1:0] a_in,
		input logic signed [IN_BITS-1:0] b_in, input logic last,
		output vec_summary_t s);
		longint     ea;
		longint     eb;
		logic [127:0] dot_sq;
		logic [127:0] norm_prod;
		bit         err;
		bit         nonzero;
		ea = (longint'(a_in) <<< (64 - ELEM_BITS)) >>> (64 - ELEM_BITS);
		eb = (longint'(b_in) <<< (64 - ELEM_BITS)) >>> (64 - ELEM_BITS);
		s = '0;
		if (pair_cnt < MAX_LEN + 1)
			pair_cnt++;
		if (pair_cnt <= MAX_LEN) begin
			dot_sum += ea * eb;
			sq_a    += u64_t'(ea * ea);
			sq_b    += u64_t'(eb * eb);
		end
		if (!last)
			return 1'b0;
		err     = pair_cnt < 2 || pair_cnt > MAX_LEN;
		nonzero = sq_a != 0 && sq_b != 0;
		if (!err && nonzero) begin
			s.orthogonal = dot_sum == 0;
			if (dot_sum > 0) begin
				dot_sq    = 128'(dot_sum) * 128'(dot_sum);
				norm_prod = 128'(sq_a) * 128'(sq_b);
				s.same_direction = dot_sq == norm_prod;
			end
		end
		s.dot          = dot_sum[DOT_BITS-1:0];
		s.mag_a        = floor_root(sq_a);
		s.mag_b        = floor_root(sq_b);
		s.length_error = err;
		dot_sum  = 0;
		sq_a     = 0;
		sq_b     = 0;
		pair_cnt = 0;
		return 1'b1;
	endfunction

	// Mostly short gaps, a few long ones, none while idling is off
	function automatic int next_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one pair at the falling edge, hold it until the transfer
	task automatic send_pair(input logic signed [IN_BITS-1:0] a,
		input logic signed [IN_BITS-1:0] b, input logic last,
		input logic fixed, input vec_summary_t typed);
		int           gap;
		vec_summary_t s;
		gap = next_gap();
		repeat (gap) begin
			@(negedge clk);
			elems_ch.valid = 1'b0;
		end
		@(negedge clk);
		elems_ch.valid  = 1'b1;
		elems_ch.elem_a = a;
		elems_ch.elem_b = b;
		elems_ch.last   = last;
		do
			@(posedge clk);
		while (elems_ch.ready !== 1'b1);
		if (fold_pair(a, b, last, s)) begin
			if (fixed)
				s = typed;
			pending_summaries.insert(pending_summaries.size(), s);
		end
	endtask

	// Park the sender until every pending summary has been taken
	task automatic wait_drained();
		@(negedge clk);
		elems_ch.valid = 1'b0;
		while (pending_summaries.size() != 0)
			@(posedge clk);
	endtask

	// One whole vector pair of the given length and shape
	task automatic send_vector(input int len, input vec_shape_t shape);
		logic signed [IN_BITS-1:0] a;
		logic signed [IN_BITS-1:0] b;
		logic signed [IN_BITS-1:0] x;
		logic signed [IN_BITS-1:0] y;
		logic signed [IN_BITS-1:0] corner [6];
		int  ka;
		int  kb;
		int  v;
		bit  zero_a;
		corner = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
		ka     = $urandom_range(1, 4);
		kb     = $urandom_range(1, 4);
		if ($urandom_range(0, 2) == 0)
			kb = -kb;
		zero_a = $urandom_range(0, 1);
		x = '0;
		y = '0;
		for (int i = 0; i < len; i++) begin
			case (shape)
				SHAPE_WIDE: begin
					a = IN_BITS'($urandom);
					b = IN_BITS'($urandom);
				end
				SHAPE_NARROW: begin
					a = IN_BITS'(int'($urandom_range(0, 30)) - 15);
					b = IN_BITS'(int'($urandom_range(0, 30)) - 15);
				end
				SHAPE_PARALLEL: begin
					v = int'($urandom_range(0, 16382)) - 8191;
					a = IN_BITS'(ka * v);
					b = IN_BITS'(kb * v);
				end
				SHAPE_ORTHO: begin
					// 2-D blocks (x, y) against (-y, x) cancel in the dot
					if (i % 2 == 0) begin
						x = IN_BITS'(int'($urandom_range(0, 65534)) - 32767);
						y = IN_BITS'(int'($urandom_range(0, 65534)) - 32767);
						a = x;
						b = (i == len - 1) ? '0 : -y;
					end else begin
						a = y;
						b = x;
					end
				end
				SHAPE_ZERO: begin
					a = zero_a ? '0 : IN_BITS'($urandom);
					b = zero_a ? IN_BITS'($urandom) : '0;
				end
				default: begin
					a = corner[$urandom_range(0, 5)];
					b = corner[$urandom_range(0, 5)];
				end
			endcase
			send_pair(a, b, i == len - 1, 1'b0, '0);
		end
	endtask

	task automatic check_field(input string name, input logic signed [63:0] want,
		input logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_cnt++;
		end
	endtask

	// Result side: random back-pressure
	initial begin
		int stall;
		stall = 0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				result_ch.ready = 1'b0;
				stall--;
			end else begin
				result_ch.ready = 1'b1;
				stall = next_gap();
			end
		end
	end

	// Compare each result transfer against the oldest pending summary
	always @(posedge clk) begin
		vec_summary_t want;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_summaries.size() == 0) begin
				$error("result transfer with no summary pending");
				mismatch_cnt++;
			end else begin
				want = pending_summaries.pop_front();
				check_field("dot", want.dot, result_ch.dot);
				check_field("mag_a", want.mag_a, result_ch.mag_a);
				check_field("mag_b", want.mag_b, result_ch.mag_b);
				check_field("orthogonal", want.orthogonal, result_ch.orthogonal);
				check_field("same_direction", want.same_direction, result_ch.same_direction);
				check_field("length_error", want.length_error, result_ch.length_error);
			end
		end
	end

	// Watchdog: too long without any transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (elems_ch.valid === 1'b1 && elems_ch.ready === 1'b1) ||
			(result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// Main sequence
	initial begin
		int         random_sent;
		int         vec_idx;
		int         len;
		int         r;
		vec_shape_t shape;
		arst_n          = 1'b0;
		elems_ch.valid  = 1'b0;
		elems_ch.elem_a = '0;
		elems_ch.elem_b = '0;
		elems_ch.last   = 1'b0;
		dot_sum         = 0;
		sq_a            = 0;
		sq_b            = 0;
		pair_cnt        = 0;
		idle_on         = 1'b0;
		random_sent     = 0;
		vec_idx         = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table, back to back first
		for (int i = 0; i < N_DIR; i++)
			send_pair(DIR_TAB[i].a, DIR_TAB[i].b, DIR_TAB[i].last,
				DIR_TAB[i].fixed, DIR_TAB[i].summary);
		wait_drained();

		// Random vectors, idling switched per block of sixteen
		while (random_sent < RANDOM_PAIRS) begin
			if (vec_idx % 16 == 0)
				idle_on = $urandom_range(0, 3) != 0;
			if (vec_idx == 20) begin
				len = MAX_LEN;
			end else if (vec_idx == 45) begin
				len = MAX_LEN + 1 + $urandom_range(0, 3);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 5)
					len = 1;
				else if (r < 90)
					len = $urandom_range(2, 8);
				else
					len = $urandom_range(9, 40);
			end
			shape = vec_shape_t'($urandom_range(0, 5));
			if (vec_idx == 30)
				wait_drained();
			send_vector(len, shape);
			random_sent += len;
			vec_idx++;
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_cnt == 0 && pending_summaries.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
